// File: rtl/core/bpe_pkg.sv
// Shared types, constants and curve tables for the battery percent estimator.
package bpe_pkg;

  // Field widths.
  localparam int unsigned AdcWidth     = 14;
  localparam int unsigned GainWidth    = 16;
  localparam int unsigned MvWidth      = 18;
  localparam int unsigned PctWidth     = 7;
  localparam int unsigned ProdWidth    = AdcWidth + GainWidth;
  localparam int unsigned CurveMvWidth = 13;

  // Defaults and limits.
  localparam int unsigned GainFracBitsDefault = 12;
  localparam logic [GainWidth-1:0] GainReset  = 16'd8192;
  localparam logic [MvWidth-1:0] MvSaturation = 18'd262143;
  localparam logic [MvWidth-1:0] PresentMinMv = 18'd2500;
  localparam logic [MvWidth-1:0] PresentMaxMv = 18'd5000;

  // Discharge curve: knee voltages and percent at each knee.
  localparam int unsigned CurvePoints = 12;
  localparam int unsigned SegWidth    = 4;
  localparam logic [CurveMvWidth-1:0] CurveMv [CurvePoints] = '{
    13'd3300, 13'd3500, 13'd3600, 13'd3700, 13'd3750, 13'd3800,
    13'd3850, 13'd3900, 13'd3950, 13'd4000, 13'd4100, 13'd4200
  };
  localparam logic [PctWidth-1:0] CurvePct [CurvePoints] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  // Per-segment interpolation terms, indexed by the upper knee. The rounded
  // numerator off*dpct + dmv/2 is scaled by 200/dmv so that every segment
  // divides by the same constant of 200.
  localparam logic [3:0] SegDpct [CurvePoints] = '{
    4'd0, 4'd5, 4'd5, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10
  };
  localparam logic [6:0] SegHalf [CurvePoints] = '{
    7'd0, 7'd100, 7'd50, 7'd50, 7'd25, 7'd25, 7'd25, 7'd25, 7'd25, 7'd25, 7'd50, 7'd50
  };
  localparam logic [2:0] SegScale [CurvePoints] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2
  };

  // Scaled numerator width and the reciprocal used for the divide by 25.
  localparam int unsigned NumWidth   = 12;
  localparam int unsigned RecipMul   = 41;
  localparam int unsigned RecipShift = 10;

  // One word held in the queue between the front and back parts.
  typedef struct packed {
    logic [AdcWidth-1:0]  adc;
    logic [ProdWidth-1:0] prod;
  } bpe_item_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } bpe_queue_status_t;

endpackage

// File: rtl/core/bpe_front.sv
// Front part: holds the gain register, accepts readings and forms the raw product.
module bpe_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                divider_gain_we_i,
  input  logic [bpe_pkg::GainWidth-1:0]       divider_gain_i,
  input  logic [bpe_pkg::AdcWidth-1:0]        adc_millivolts_i,
  input  bpe_pkg::bpe_queue_status_t          queue_status_i,
  output logic                                push_o,
  output bpe_pkg::bpe_item_t                  item_o
);

  logic [bpe_pkg::GainWidth-1:0] gain_q;
  logic                          valid_q, valid_d;
  bpe_pkg::bpe_item_t            item_q;
  logic                          load;

  // Gain register, written whenever the enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= bpe_pkg::GainReset;
    end else if (divider_gain_we_i) begin
      gain_q <= divider_gain_i;
    end
  end

  // The stage holds its word while the queue is full.
  assign busy_o = valid_q && queue_status_i.full;
  assign push_o = valid_q && !queue_status_i.full;
  assign load   = !busy_o;
  assign valid_d = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_d;
    end
  end

  // Payload: the reading and its product with the gain.
  always_ff @(posedge clk_i) begin
    if (load && valid_d) begin
      item_q.adc  <= adc_millivolts_i;
      item_q.prod <= bpe_pkg::ProdWidth'(adc_millivolts_i) *
                     bpe_pkg::ProdWidth'(gain_q);
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/core/bpe_queue.sv
// Two-entry queue that decouples the front and back parts.
module bpe_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bpe_pkg::bpe_item_t         item_i,
  input  logic                       pop_i,
  output bpe_pkg::bpe_item_t         item_o,
  output bpe_pkg::bpe_queue_status_t status_o
);

  bpe_pkg::bpe_item_t entries_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q, count_d;
  logic               do_push, do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign do_push = push_i && (count_q != 2'd2);

  // Occupancy count.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Storage for the words in flight.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

// File: rtl/core/bpe_back.sv
// Back part: rounds and saturates, checks presence and interpolates the curve.
module bpe_back #(
  parameter int unsigned GainFracBits = bpe_pkg::GainFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpe_pkg::bpe_queue_status_t       queue_status_i,
  input  bpe_pkg::bpe_item_t               item_i,
  output logic                             pop_o,
  output logic                             valid_o,
  output logic [bpe_pkg::AdcWidth-1:0]     adc_echo_millivolts_o,
  output logic [bpe_pkg::MvWidth-1:0]      scaled_millivolts_o,
  output logic                             battery_present_o,
  output logic [bpe_pkg::PctWidth-1:0]     charge_percent_o
);

  localparam int unsigned SumWidth = bpe_pkg::ProdWidth + 1;
  localparam logic [SumWidth-1:0] RoundHalf = SumWidth'(1) << (GainFracBits - 1);

  // The back part never stalls: it takes a word whenever one is queued.
  assign pop_o = !queue_status_i.empty;

  // Stage A: round to nearest and saturate.
  logic                            valid_a_q;
  logic [bpe_pkg::AdcWidth-1:0]    adc_a_q;
  logic [bpe_pkg::MvWidth-1:0]     mv_a_q, mv_a_d;
  logic [SumWidth-1:0]             rounded;
  logic [SumWidth-1:0]             shifted;

  always_comb begin
    rounded = SumWidth'(item_i.prod) + RoundHalf;
    shifted = rounded >> GainFracBits;
    if (shifted > SumWidth'(bpe_pkg::MvSaturation)) begin
      mv_a_d = bpe_pkg::MvSaturation;
    end else begin
      mv_a_d = shifted[bpe_pkg::MvWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      adc_a_q <= item_i.adc;
      mv_a_q  <= mv_a_d;
    end
  end

  // Stage B: presence, segment search and the scaled numerator.
  logic                                valid_b_q;
  logic [bpe_pkg::AdcWidth-1:0]        adc_b_q;
  logic [bpe_pkg::MvWidth-1:0]         mv_b_q;
  logic                                present_b_q, present_d;
  logic [bpe_pkg::PctWidth-1:0]        base_b_q, base_d;
  logic [bpe_pkg::NumWidth-1:0]        num_b_q, num_d;
  logic [bpe_pkg::SegWidth-1:0]        seg;
  logic [bpe_pkg::SegWidth-1:0]        seg_lo;
  logic [7:0]                          offset;
  logic [bpe_pkg::NumWidth-1:0]        rounded_num;
  logic [bpe_pkg::NumWidth+2:0]        scaled_num;

  always_comb begin
    present_d = (mv_a_q >= bpe_pkg::PresentMinMv) && (mv_a_q <= bpe_pkg::PresentMaxMv);
    // First knee at or above the voltage; knees are checked in parallel.
    seg = bpe_pkg::SegWidth'(bpe_pkg::CurvePoints - 1);
    for (int k = bpe_pkg::CurvePoints - 1; k >= 1; k--) begin
      if (mv_a_q <= bpe_pkg::MvWidth'(bpe_pkg::CurveMv[k])) begin
        seg = bpe_pkg::SegWidth'(k);
      end
    end
    seg_lo      = seg - bpe_pkg::SegWidth'(1);
    offset      = 8'(mv_a_q[bpe_pkg::CurveMvWidth-1:0] - bpe_pkg::CurveMv[seg_lo]);
    rounded_num = bpe_pkg::NumWidth'(offset) * bpe_pkg::NumWidth'(bpe_pkg::SegDpct[seg])
                + bpe_pkg::NumWidth'(bpe_pkg::SegHalf[seg]);
    scaled_num  = (bpe_pkg::NumWidth+3)'(rounded_num) *
                  (bpe_pkg::NumWidth+3)'(bpe_pkg::SegScale[seg]);
    // Below the curve, above it, or absent: a fixed percent and no fraction.
    if (!present_d || (mv_a_q <= bpe_pkg::MvWidth'(bpe_pkg::CurveMv[0]))) begin
      base_d = '0;
      num_d  = '0;
    end else if (mv_a_q > bpe_pkg::MvWidth'(bpe_pkg::CurveMv[bpe_pkg::CurvePoints-1])) begin
      base_d = bpe_pkg::CurvePct[bpe_pkg::CurvePoints-1];
      num_d  = '0;
    end else begin
      base_d = bpe_pkg::CurvePct[seg_lo];
      num_d  = scaled_num[bpe_pkg::NumWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q) begin
      adc_b_q     <= adc_a_q;
      mv_b_q      <= mv_a_q;
      present_b_q <= present_d;
      base_b_q    <= base_d;
      num_b_q     <= num_d;
    end
  end

  // Stage C: divide by 200 as a shift by three and a reciprocal multiply by 25.
  logic                                valid_c_q;
  logic [bpe_pkg::AdcWidth-1:0]        adc_c_q;
  logic [bpe_pkg::MvWidth-1:0]         mv_c_q;
  logic                                present_c_q;
  logic [bpe_pkg::PctWidth-1:0]        pct_c_q, pct_d;
  logic [bpe_pkg::NumWidth-4:0]        num_eighths;
  logic [bpe_pkg::NumWidth+3:0]        recip_prod;
  logic [bpe_pkg::NumWidth+3:0]        quotient;

  always_comb begin
    num_eighths = num_b_q[bpe_pkg::NumWidth-1:3];
    recip_prod  = (bpe_pkg::NumWidth+4)'(num_eighths) *
                  (bpe_pkg::NumWidth+4)'(bpe_pkg::RecipMul);
    quotient    = recip_prod >> bpe_pkg::RecipShift;
    pct_d       = base_b_q + quotient[bpe_pkg::PctWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_b_q) begin
      adc_c_q     <= adc_b_q;
      mv_c_q      <= mv_b_q;
      present_c_q <= present_b_q;
      pct_c_q     <= pct_d;
    end
  end

  assign valid_o               = valid_c_q;
  assign adc_echo_millivolts_o = adc_c_q;
  assign scaled_millivolts_o   = mv_c_q;
  assign battery_present_o     = present_c_q;
  assign charge_percent_o      = pct_c_q;

endmodule

// File: rtl/core/battery_percent_estimator.sv
// Top level of the battery percent estimator: front part, queue and back part.
// A reading taken by the front part with its gain product passes the two-entry
// queue and three back stages; its result shows with valid_o, held for one
// cycle. Throughput: one reading per clock while busy_o is low. The receiver
// cannot stall; busy_o is high only while the queue is full. Reset clears all
// valid flags and loads the gain with x2.0.
module battery_percent_estimator #(
  parameter int unsigned GainFracBits = bpe_pkg::GainFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             divider_gain_we_i,
  input  logic [bpe_pkg::GainWidth-1:0]    divider_gain_i,
  input  logic [bpe_pkg::AdcWidth-1:0]     adc_millivolts_i,
  output logic                             valid_o,
  output logic [bpe_pkg::AdcWidth-1:0]     adc_echo_millivolts_o,
  output logic [bpe_pkg::MvWidth-1:0]      scaled_millivolts_o,
  output logic                             battery_present_o,
  output logic [bpe_pkg::PctWidth-1:0]     charge_percent_o
);

  bpe_pkg::bpe_queue_status_t queue_status;
  bpe_pkg::bpe_item_t         push_item;
  bpe_pkg::bpe_item_t         head_item;
  logic                       push;
  logic                       pop;

  // Front part: accepts readings and forms the product.
  bpe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .divider_gain_we_i (divider_gain_we_i),
    .divider_gain_i    (divider_gain_i),
    .adc_millivolts_i  (adc_millivolts_i),
    .queue_status_i    (queue_status),
    .push_o            (push),
    .item_o            (push_item)
  );

  // Queue between the two parts.
  bpe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (queue_status)
  );

  // Back part: voltage, presence and percent.
  bpe_back #(
    .GainFracBits (GainFracBits)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .queue_status_i        (queue_status),
    .item_i                (head_item),
    .pop_o                 (pop),
    .valid_o               (valid_o),
    .adc_echo_millivolts_o (adc_echo_millivolts_o),
    .scaled_millivolts_o   (scaled_millivolts_o),
    .battery_present_o     (battery_present_o),
    .charge_percent_o      (charge_percent_o)
  );

endmodule

// File: tb/battery_percent_estimator_tb.sv
// Self-checking testbench for the battery percent estimator, with directed and random readings.
`timescale 1ns / 1ps

module battery_percent_estimator_tb;

  localparam int unsigned FracBits   = bpe_pkg::GainFracBitsDefault;
  localparam int unsigned KneeCount  = 12;
  localparam int unsigned SegCount   = 8;
  localparam int unsigned SegItems   = 140;
  localparam int unsigned CycleLimit = 200000;

  // Discharge curve knees, kept apart from the design's own tables.
  localparam int unsigned KNEE_MV [KneeCount] = '{
    3300, 3500, 3600, 3700, 3750, 3800, 3850, 3900, 3950, 4000, 4100, 4200
  };
  localparam int unsigned KNEE_PCT [KneeCount] = '{
    0, 5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
  };

  // Percent chance of an idle cycle before each word, per phase.
  localparam int unsigned IDLE_PCT [4] = '{0, 83, 0, 32};

  typedef struct packed {
    logic [bpe_pkg::AdcWidth-1:0] adc;
    logic [bpe_pkg::MvWidth-1:0]  mv;
    logic                         present;
    logic [bpe_pkg::PctWidth-1:0] pct;
  } battery_estimate_t;

  // One directed reading; when hand_typed is set the expected fields are taken as written.
  typedef struct packed {
    logic [bpe_pkg::GainWidth-1:0] gain;
    logic [bpe_pkg::AdcWidth-1:0]  adc;
    logic                          hand_typed;
    logic [bpe_pkg::MvWidth-1:0]   mv;
    logic                          present;
    logic [bpe_pkg::PctWidth-1:0]  pct;
  } reading_row_t;

  localparam int unsigned RowCount = 24;
  localparam reading_row_t READING_ROWS [RowCount] = '{
    // Reset gain of x2.0.
    '{16'd8192,  14'd0,     1'b1, 18'd0,      1'b0, 7'd0},
    '{16'd8192,  14'd16383, 1'b1, 18'd32766,  1'b0, 7'd0},
    '{16'd8192,  14'd1750,  1'b1, 18'd3500,   1'b1, 7'd5},
    '{16'd8192,  14'd1250,  1'b1, 18'd2500,   1'b1, 7'd0},
    '{16'd8192,  14'd2100,  1'b1, 18'd4200,   1'b1, 7'd100},
    // Zero gain scales every reading to zero millivolts.
    '{16'd0,     14'd16383, 1'b1, 18'd0,      1'b0, 7'd0},
    '{16'd0,     14'd8191,  1'b1, 18'd0,      1'b0, 7'd0},
    // Unity gain: window edges, curve ends and segment interiors.
    '{16'd4096,  14'd2499,  1'b1, 18'd2499,   1'b0, 7'd0},
    '{16'd4096,  14'd2500,  1'b1, 18'd2500,   1'b1, 7'd0},
    '{16'd4096,  14'd3300,  1'b1, 18'd3300,   1'b1, 7'd0},
    '{16'd4096,  14'd3301,  1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd4096,  14'd3400,  1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd4096,  14'd3650,  1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd4096,  14'd3975,  1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd4096,  14'd4150,  1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd4096,  14'd4200,  1'b1, 18'd4200,   1'b1, 7'd100},
    '{16'd4096,  14'd4201,  1'b1, 18'd4201,   1'b1, 7'd100},
    '{16'd4096,  14'd5000,  1'b1, 18'd5000,   1'b1, 7'd100},
    '{16'd4096,  14'd5001,  1'b1, 18'd5001,   1'b0, 7'd0},
    // Half gain: a tie in rounding goes up.
    '{16'd2048,  14'd1,     1'b1, 18'd1,      1'b0, 7'd0},
    '{16'd2048,  14'd7001,  1'b0, 18'd0,      1'b0, 7'd0},
    // Largest gain and the smallest nonzero gain.
    '{16'd65535, 14'd16383, 1'b1, 18'd262124, 1'b0, 7'd0},
    '{16'd65535, 14'd10000, 1'b0, 18'd0,      1'b0, 7'd0},
    '{16'd1,     14'd16383, 1'b1, 18'd4,      1'b0, 7'd0}
  };

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          start_i           = 1'b0;
  logic                          divider_gain_we_i = 1'b0;
  logic [bpe_pkg::GainWidth-1:0] divider_gain_i    = '0;
  logic [bpe_pkg::AdcWidth-1:0]  adc_millivolts_i  = '0;
  logic                          busy_o;
  logic                          valid_o;
  logic [bpe_pkg::AdcWidth-1:0]  adc_echo_millivolts_o;
  logic [bpe_pkg::MvWidth-1:0]   scaled_millivolts_o;
  logic                          battery_present_o;
  logic [bpe_pkg::PctWidth-1:0]  charge_percent_o;

  logic [bpe_pkg::GainWidth-1:0] active_gain = bpe_pkg::GainReset;
  battery_estimate_t             pending_estimates [$];
  int unsigned                   mismatch_count = 0;
  int unsigned                   cycle_count    = 0;

  battery_percent_estimator DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .divider_gain_we_i     (divider_gain_we_i),
    .divider_gain_i        (divider_gain_i),
    .adc_millivolts_i      (adc_millivolts_i),
    .valid_o               (valid_o),
    .adc_echo_millivolts_o (adc_echo_millivolts_o),
    .scaled_millivolts_o   (scaled_millivolts_o),
    .battery_present_o     (battery_present_o),
    .charge_percent_o      (charge_percent_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Scale one reading, test the presence window and look up the charge on the curve.
  function automatic battery_estimate_t estimate_battery(
      input logic [bpe_pkg::AdcWidth-1:0] adc, input logic [bpe_pkg::GainWidth-1:0] gain);
    battery_estimate_t est;
    logic [63:0]       scaled;
    int unsigned       mv;
    int unsigned       span;
    int unsigned       rise;
    int                k;
    scaled = (64'(adc) * 64'(gain) + (64'd1 << (FracBits - 1))) >> FracBits;
    if (scaled > 64'd262143) begin
      scaled = 64'd262143;
    end
    mv          = int'(scaled[bpe_pkg::MvWidth-1:0]);
    est.adc     = adc;
    est.mv      = scaled[bpe_pkg::MvWidth-1:0];
    est.present = (mv >= 2500) && (mv <= 5000);
    est.pct     = '0;
    if (est.present && mv > KNEE_MV[0]) begin
      est.pct = 7'd100;
      // Walk down so that the lowest knee at or above the voltage wins.
      for (k = KneeCount - 1; k >= 1; k--) begin
        if (mv <= KNEE_MV[k]) begin
          span    = KNEE_MV[k] - KNEE_MV[k-1];
          rise    = KNEE_PCT[k] - KNEE_PCT[k-1];
          est.pct = 7'(KNEE_PCT[k-1] + ((mv - KNEE_MV[k-1]) * rise + span / 2) / span);
        end
      end
    end
    return est;
  endfunction

  // Offer one word and hold it until accepted; start stays high on return.
  task automatic send_reading(input logic [bpe_pkg::AdcWidth-1:0] adc, input logic hand_typed,
                              input battery_estimate_t typed_est);
    logic taken;
    start_i          <= 1'b1;
    adc_millivolts_i <= adc;
    // busy_o comes from registers only, so its mid-cycle value holds at the next edge.
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    if (hand_typed) begin
      pending_estimates.push_back(typed_est);
    end else begin
      pending_estimates.push_back(estimate_battery(adc, active_gain));
    end
  endtask

  // Drain the pipeline, then load a new divider gain.
  task automatic program_gain(input logic [bpe_pkg::GainWidth-1:0] gain);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_estimates.size() != 0) begin
      @(posedge clk_i);
    end
    divider_gain_we_i <= 1'b1;
    divider_gain_i    <= gain;
    @(posedge clk_i);
    divider_gain_we_i <= 1'b0;
    active_gain = gain;
  endtask

  // Compare each result word with the oldest pending estimate.
  always @(posedge clk_i) begin
    battery_estimate_t want;
    if (rst_ni && valid_o) begin
      if (pending_estimates.size() == 0) begin
        $error("result word with no pending estimate: adc_echo_millivolts %0d",
               adc_echo_millivolts_o);
        mismatch_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (adc_echo_millivolts_o !== want.adc) begin
          $error("adc_echo_millivolts: expected %0d, got %0d", want.adc, adc_echo_millivolts_o);
          mismatch_count++;
        end
        if (scaled_millivolts_o !== want.mv) begin
          $error("scaled_millivolts: expected %0d, got %0d", want.mv, scaled_millivolts_o);
          mismatch_count++;
        end
        if (battery_present_o !== want.present) begin
          $error("battery_present: expected %0d, got %0d", want.present, battery_present_o);
          mismatch_count++;
        end
        if (charge_percent_o !== want.pct) begin
          $error("charge_percent: expected %0d, got %0d", want.pct, charge_percent_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: directed table first, then random readings over several gain phases.
  initial begin
    battery_estimate_t             typed_est;
    logic [bpe_pkg::GainWidth-1:0] seg_gain [SegCount];
    logic [bpe_pkg::AdcWidth-1:0]  adc;
    int unsigned                   target_mv;
    int unsigned                   wide_adc;
    int unsigned                   idle_pct;
    int                            row;
    int                            seg;
    int                            n;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings.
    for (row = 0; row < RowCount; row++) begin
      if (READING_ROWS[row].gain != active_gain) begin
        program_gain(READING_ROWS[row].gain);
      end
      typed_est.adc     = READING_ROWS[row].adc;
      typed_est.mv      = READING_ROWS[row].mv;
      typed_est.present = READING_ROWS[row].present;
      typed_est.pct     = READING_ROWS[row].pct;
      send_reading(READING_ROWS[row].adc, READING_ROWS[row].hand_typed, typed_est);
    end

    // Random readings; most are aimed at the presence window for the phase's gain.
    seg_gain = '{16'd65535, 16'd0, 16'd4096, 16'($urandom_range(2048, 16384)), 16'd8192,
                 16'($urandom_range(0, 65535)), 16'd1, 16'($urandom_range(3000, 9000))};
    for (seg = 0; seg < SegCount; seg++) begin
      program_gain(seg_gain[seg]);
      idle_pct = IDLE_PCT[seg % 4];
      for (n = 0; n < SegItems; n++) begin
        if (seg_gain[seg] != 0 && $urandom_range(99) < 75) begin
          target_mv = $urandom_range(2400, 5100);
          wide_adc  = (target_mv * 4096 + seg_gain[seg] / 2) / seg_gain[seg];
          adc       = (wide_adc > 16383) ? 14'd16383 : 14'(wide_adc);
        end else begin
          adc = 14'($urandom_range(0, 16383));
        end
        while ($urandom_range(99) < idle_pct) begin
          start_i <= 1'b0;
          @(posedge clk_i);
        end
        send_reading(adc, 1'b0, '0);
      end
    end

    // Let the last results drain, then give the verdict.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_estimates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
